// ===== hw/rtl/cht_pkg.sv =====
// Package for the chained hash table engine: word types, command and status
// codes, controller states and the controller/datapath interface structs.
// No dependencies.
package cht_pkg;

  localparam int unsigned BUCKETS_DEF = 10;
  localparam int unsigned WAYS_DEF    = 8;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_LOOKUP  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_INSPECT = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_BADBKT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [3:0]         bucket;
    logic [3:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic signed [31:0] out_value;
    logic [3:0]         bucket_size;
    logic               removed;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_MOD_MUL,
    S_MOD_RED,
    S_READ,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_INSP_RD,
    S_INSP_WAIT,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic hash;       // take key magnitude
    logic mod_mul;    // reciprocal product of the magnitude
    logic mod_red;    // remainder gives home bucket
    logic rd_scan;    // issue memory read at scan index
    logic scan_inc;   // advance scan index
    logic sh_rd;      // read entry at scan index + 1
    logic sh_wr;      // write shifted entry to scan index
    logic do_write;   // perform insert write / delete count update
    logic insp_rd;    // issue inspect read
    logic finish;     // form result
    logic clear;      // clear all counts
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] command;
    logic       scan_end;   // scan index reached bucket count
    logic       hit;        // key at scan index matches
    logic       shift_end;  // no further entry to move
    logic       bad_bucket;
  } sts_t;

endpackage

// ===== hw/rtl/cht_ctrl.sv =====
// Controller state machine of the hash table engine.
// Depends on cht_pkg.
module cht_ctrl
  import cht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy,
  output logic done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_HASH;
      S_HASH: begin
        if (sts.command == CMD_INSERT || sts.command == CMD_LOOKUP ||
            sts.command == CMD_DELETE)
          state_next = S_MOD_MUL;
        else if (sts.command == CMD_INSPECT && !sts.bad_bucket)
          state_next = S_INSP_RD;
        else
          state_next = S_DONE;
      end
      S_MOD_MUL: state_next = S_MOD_RED;
      S_MOD_RED: state_next = S_READ;
      S_READ: state_next = sts.scan_end ? S_WRITE : S_CMP;
      S_CMP: begin
        if (sts.hit) begin
          if (sts.command == CMD_DELETE) state_next = S_SHIFT_RD;
          else                           state_next = S_WRITE;
        end else begin
          state_next = S_READ;
        end
      end
      S_SHIFT_RD: state_next = sts.shift_end ? S_WRITE : S_SHIFT_WR;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_WRITE:    state_next = S_DONE;
      S_INSP_RD:  state_next = S_INSP_WAIT;
      S_INSP_WAIT: state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    unique case (state)
      S_IDLE:     ctl.load = start;
      S_HASH: begin
        ctl.hash  = 1'b1;
        ctl.clear = (sts.command == CMD_CLEAR);
      end
      S_MOD_MUL:  ctl.mod_mul = 1'b1;
      S_MOD_RED:  ctl.mod_red = 1'b1;
      S_READ:     ctl.rd_scan = 1'b1;
      S_CMP:      ctl.scan_inc = !sts.hit;
      S_SHIFT_RD: ctl.sh_rd = 1'b1;
      S_SHIFT_WR: ctl.sh_wr = 1'b1;
      S_WRITE:    ctl.do_write = 1'b1;
      S_INSP_RD:  ctl.insp_rd = 1'b1;
      S_INSP_WAIT: ctl.finish = 1'b0;
      S_DONE: begin
        ctl.finish = 1'b1;
        done       = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/cht_dp.sv =====
// Datapath of the hash table engine: key/value memories, bucket counts,
// home bucket reduction, scan index and result forming. Depends on cht_pkg.
module cht_dp
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned WAYS    = WAYS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  ctl_t      ctl,
  output sts_t      sts,
  output out_word_t out_word
);

  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned BW    = $clog2(BUCKETS);
  localparam int unsigned PW    = $clog2(WAYS + 1);
  // reciprocal of BUCKETS, exact quotient for any 32-bit magnitude
  localparam int unsigned RS    = $clog2(BUCKETS);
  localparam logic [63:0] RECIP =
    ((64'd1 << (32 + RS)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  logic signed [31:0] key_mem [SLOTS];
  logic signed [31:0] val_mem [SLOTS];
  logic [3:0]         cnt [BUCKETS];

  in_word_t   req;
  logic [BW-1:0] bkt;
  logic [PW-1:0] idx;
  logic [3:0]    n;
  logic [31:0]   mag;
  logic [67:0]   prod;
  logic [31:0]   quo;
  logic signed [31:0] rd_key, rd_val;
  logic          found;
  logic [AW-1:0] addr, addr_nx;

  // |key| mod BUCKETS: magnitude, reciprocal product, then remainder
  logic [31:0] mag_c;
  assign mag_c = req.key[31] ? (32'd0 - req.key) : req.key;
  assign quo   = prod[32 + RS +: 32];

  assign addr    = AW'(bkt * WAYS) + AW'(idx);
  assign addr_nx = addr + AW'(1);

  always_ff @(posedge clk) begin
    if (ctl.load) req <= in_word;
    if (ctl.hash) begin
      mag   <= mag_c;
      bkt   <= BW'(req.bucket);
      idx   <= '0;
      found <= 1'b0;
    end
    if (ctl.mod_mul) prod <= 68'(mag) * 68'(RECIP);
    if (ctl.mod_red) bkt <= BW'(mag - quo * 32'(BUCKETS));
    if (ctl.scan_inc) idx <= idx + PW'(1);
    if (ctl.rd_scan) begin
      rd_key <= key_mem[addr];
      rd_val <= val_mem[addr];
    end
    if (ctl.sh_rd) begin
      rd_key <= key_mem[addr_nx];
      rd_val <= val_mem[addr_nx];
    end
    if (ctl.sh_wr) begin
      key_mem[addr] <= rd_key;
      val_mem[addr] <= rd_val;
      idx <= idx + PW'(1);
    end
    if (ctl.insp_rd) begin
      rd_key <= key_mem[AW'(bkt * WAYS) + AW'(req.position)];
      rd_val <= val_mem[AW'(bkt * WAYS) + AW'(req.position)];
    end
    if (ctl.do_write && req.command == CMD_INSERT && !sts.scan_end) begin
      val_mem[addr] <= req.value;
    end else if (ctl.do_write && req.command == CMD_INSERT && n < 4'(WAYS)) begin
      key_mem[addr] <= req.key;
      val_mem[addr] <= req.value;
    end
    // insert: set unless refused as full
    if (ctl.do_write)
      found <= !sts.scan_end || (req.command == CMD_INSERT && n < 4'(WAYS)) ||
               (req.command == CMD_DELETE);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < BUCKETS; i++) cnt[i] <= '0;
    end else if (ctl.do_write) begin
      if (req.command == CMD_INSERT && sts.scan_end && n < 4'(WAYS))
        cnt[bkt] <= n + 4'd1;
      else if (req.command == CMD_DELETE && !sts.scan_end)
        cnt[bkt] <= n - 4'd1;
    end
  end

  assign n = (32'(bkt) < BUCKETS) ? cnt[bkt] : 4'd0;

  assign sts.command    = req.command;
  assign sts.scan_end   = ({{(32-PW){1'b0}}, idx} >= 32'(n));
  assign sts.hit        = (rd_key == req.key);
  assign sts.shift_end  = ({{(32-PW){1'b0}}, idx} + 32'd1 >= 32'(n));
  assign sts.bad_bucket = ({28'd0, req.bucket} >= 32'(BUCKETS));

  // for delete, a hit leaves scan_end low; the shift loop then runs idx to
  // the end, so the hit is held in 'hit_del', set once the shift states run
  logic hit_del;
  always_ff @(posedge clk) begin
    if (ctl.hash) hit_del <= 1'b0;
    else if (ctl.sh_rd || ctl.sh_wr) hit_del <= 1'b1;
  end

  always_comb begin
    out_word = '0;
    unique case (req.command)
      CMD_INSERT: out_word.status = found ? ST_OK : ST_FULL;
      CMD_LOOKUP: begin
        out_word.status    = found ? ST_OK : ST_NOTFOUND;
        out_word.out_value = found ? rd_val : -32'sd1;
      end
      CMD_DELETE: begin
        out_word.status  = hit_del ? ST_OK : ST_NOTFOUND;
        out_word.removed = hit_del;
      end
      CMD_INSPECT: begin
        if (sts.bad_bucket) begin
          out_word.status    = ST_BADBKT;
          out_word.out_key   = -32'sd1;
          out_word.out_value = -32'sd1;
        end else if ({28'd0, req.position} < 32'(n)) begin
          out_word.out_key     = rd_key;
          out_word.out_value   = rd_val;
          out_word.bucket_size = n;
        end else begin
          out_word.status      = ST_NOTFOUND;
          out_word.out_key     = -32'sd1;
          out_word.out_value   = -32'sd1;
          out_word.bucket_size = n;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/chained_hash_table_engine_top.sv =====
// Top level of the chained hash table engine.
// Depends on cht_pkg, cht_ctrl, cht_dp.
//
// Usage:
//  - Drive a command word on in_word and raise start while busy is low; the
//    word is taken at that edge. busy stays high until the result is shown.
//  - The result word appears on out_word for one cycle with done high.
//    The receiver cannot stall; the word must be taken in that cycle.
//  - After the result the engine returns to idle before the next word is taken.
//  - Each key is reduced in turn (magnitude, reciprocal product, remainder),
//    then the bucket is walked in the single-port key/value memory one
//    entry at a time, a read and then a compare for each entry.
//  - One command at a time; start while busy is ignored.
//  - Reset empties every bucket (counts cleared); key and value memories
//    are not cleared, unused entries are never shown in a result.
//  - Bucket of a key is |key| mod BUCKETS; each bucket holds WAYS entries.
module chained_hash_table_engine_top
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned WAYS    = WAYS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      done,
  output out_word_t out_word
);

  ctl_t ctl;
  sts_t sts;

  cht_ctrl u_ctrl (
    .clk (clk), .rst (rst), .start (start), .sts (sts),
    .ctl (ctl), .busy (busy), .done (done)
  );

  cht_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
    .clk (clk), .rst (rst), .in_word (in_word), .ctl (ctl),
    .sts (sts), .out_word (out_word)
  );

endmodule

// ===== hw/rtl/cht_checker.sv =====
// Port checker for the hash table engine, bound to the top level.
// Depends on cht_pkg.
module cht_checker
  import cht_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_word_t out_word
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result outside command");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");

  a_removed: assert property (@(posedge clk) disable iff (rst)
    (done && out_word.removed) |-> out_word.status == ST_OK)
    else $error("removed with bad status");

endmodule

bind chained_hash_table_engine_top cht_checker u_chk (
  .clk (clk), .rst (rst), .start (start), .busy (busy), .done (done),
  .out_word (out_word)
);

// ===== bench/chained_hash_table_engine_top_test.sv =====
// Testbench for the chained hash table engine: directed and random command
// words checked against a behavioural table model. Depends on cht_pkg and
// chained_hash_table_engine_top.
`timescale 1ns / 100ps

module chained_hash_table_engine_top_test;
  import cht_pkg::*;

  localparam int NBKT = 10;
  localparam int NWAY = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst;
  logic      start;
  in_word_t  in_word;
  logic      busy;
  logic      done;
  out_word_t out_word;

  chained_hash_table_engine_top u_top (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word),
    .busy(busy), .done(done), .out_word(out_word)
  );

  // shadow copy of the table
  logic signed [31:0] tbl_key [NBKT][NWAY];
  logic signed [31:0] tbl_val [NBKT][NWAY];
  int                 tbl_cnt [NBKT];

  out_word_t result_q [$];
  int        n_mismatch;
  int        n_words;
  int        n_results;
  int        n_full;
  int        n_removed;
  int        cycles;

  // pool of keys so that hits, repeats and full buckets are common
  logic signed [31:0] key_pool [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // bucket of a key, magnitude of the most negative key taken as 2^31
  function automatic int home_of(logic signed [31:0] k);
    logic [32:0] mag;
    mag = k[31] ? ({1'b0, ~k} + 33'd1) : {1'b0, k};
    return int'(mag % NBKT);
  endfunction

  function automatic int slot_of(int b, logic signed [31:0] k);
    for (int j = 0; j < tbl_cnt[b]; j++)
      if (tbl_key[b][j] == k) return j;
    return -1;
  endfunction

  // expected result of one command word, table updated in step
  function automatic out_word_t table_apply(in_word_t w);
    out_word_t r;
    int b, p, n;
    r = '0;
    b = home_of(w.key);
    p = slot_of(b, w.key);
    case (w.command)
      CMD_CLEAR: begin
        for (int i = 0; i < NBKT; i++) tbl_cnt[i] = 0;
      end
      CMD_INSERT: begin
        if (p >= 0) tbl_val[b][p] = w.value;
        else if (tbl_cnt[b] >= NWAY) r.status = ST_FULL;
        else begin
          tbl_key[b][tbl_cnt[b]] = w.key;
          tbl_val[b][tbl_cnt[b]] = w.value;
          tbl_cnt[b]++;
        end
      end
      CMD_LOOKUP: begin
        if (p >= 0) r.out_value = tbl_val[b][p];
        else begin
          r.status = ST_NOTFOUND;
          r.out_value = -1;
        end
      end
      CMD_DELETE: begin
        if (p >= 0) begin
          n = tbl_cnt[b];
          for (int j = p; j + 1 < n; j++) begin
            tbl_key[b][j] = tbl_key[b][j + 1];
            tbl_val[b][j] = tbl_val[b][j + 1];
          end
          tbl_cnt[b] = n - 1;
          r.removed = 1'b1;
        end else r.status = ST_NOTFOUND;
      end
      CMD_INSPECT: begin
        if (w.bucket >= NBKT) begin
          r.status = ST_BADBKT;
          r.out_key = -1;
          r.out_value = -1;
        end else begin
          r.bucket_size = 4'(tbl_cnt[w.bucket]);
          if (w.position < tbl_cnt[w.bucket]) begin
            r.out_key = tbl_key[w.bucket][w.position];
            r.out_value = tbl_val[w.bucket][w.position];
          end else begin
            r.status = ST_NOTFOUND;
            r.out_key = -1;
            r.out_value = -1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checker: done is sampled at the edge that ends its cycle
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && done) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result word %h", out_word);
      end else begin
        want = result_q.pop_front();
        if (out_word.status != want.status || out_word.out_key != want.out_key ||
            out_word.out_value != want.out_value ||
            out_word.bucket_size != want.bucket_size ||
            out_word.removed != want.removed) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch: expected st=%0d k=%0d v=%0d sz=%0d rm=%0d,",
                      " got st=%0d k=%0d v=%0d sz=%0d rm=%0d"},
                     want.status, want.out_key, want.out_value, want.bucket_size,
                     want.removed, out_word.status, out_word.out_key,
                     out_word.out_value, out_word.bucket_size, out_word.removed);
        end
        if (want.status == ST_FULL) n_full++;
        if (want.removed) n_removed++;
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[chained_hash_table_engine_top] ERROR");
      $finish;
    end
  end

  // random gap before a word: mostly short, sometimes long, often none
  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 40) g = 0;
    else if (g < 92) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    repeat (g) @(posedge clk);
  endtask

  // send one command word; prediction is made as it is taken
  task automatic send_word(logic [2:0] c, logic signed [31:0] k,
                           logic signed [31:0] v, logic [3:0] b, logic [3:0] p);
    in_word_t w;
    w.command = c;
    w.key = k;
    w.value = v;
    w.bucket = b;
    w.position = p;
    idle_gap();
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    result_q.push_back(table_apply(w));
    n_words++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && key_pool.size() > 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 80) return $urandom_range(0, 200) - 100;
    if (r < 83) return 32'sh8000_0000;
    return $urandom();
  endfunction

  task automatic test_directed();
    send_word(CMD_INSPECT, 0, 0, 4'd0, 4'd0);
    send_word(CMD_LOOKUP, 5, 0, 4'd0, 4'd0);
    send_word(CMD_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 4'd0, 4'd0);
    send_word(CMD_INSERT, -32'sh7fff_ffff, 32'sh7fff_ffff, 4'd0, 4'd0);
    send_word(CMD_INSERT, 32'sh8000_0000, -1, 4'd0, 4'd0);
    send_word(CMD_LOOKUP, 32'sh8000_0000, 0, 4'd0, 4'd0);
    send_word(CMD_LOOKUP, -32'sh7fff_ffff, 0, 4'd0, 4'd0);
    // fill bucket 3 and overflow it, then update within the full bucket
    for (int i = 0; i < NWAY; i++) send_word(CMD_INSERT, 3 + 10 * i, i, 4'd0, 4'd0);
    send_word(CMD_INSERT, -93, 7, 4'd0, 4'd0);
    send_word(CMD_INSERT, 33, 32'sh1234_5678, 4'd0, 4'd0);
    send_word(CMD_DELETE, 13, 0, 4'd0, 4'd0);
    send_word(CMD_DELETE, 13, 0, 4'd0, 4'd0);
    send_word(CMD_INSPECT, 0, 0, 4'd3, 4'd1);
    send_word(CMD_INSPECT, 0, 0, 4'd3, 4'd15);
    send_word(CMD_INSPECT, 0, 0, 4'd15, 4'd0);
    send_word(3'd7, 32'shffff_ffff, -1, 4'hf, 4'hf);
    send_word(CMD_CLEAR, 0, 0, 4'd0, 4'd0);
    send_word(CMD_INSPECT, 0, 0, 4'd3, 4'd0);
  endtask

  task automatic test_random(int count);
    int r;
    logic [3:0] b;
    for (int i = 0; i < count; i++) begin
      if (key_pool.size() < 40 || $urandom_range(0, 9) == 0)
        key_pool.push_back($urandom_range(0, 3) == 0 ? $urandom() :
                           $urandom_range(0, 400) - 200);
      r = $urandom_range(0, 99);
      b = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                      : 4'($urandom_range(0, 9));
      if (r < 1)
        send_word(CMD_CLEAR, $urandom(), $urandom(), 4'($urandom()), 4'($urandom()));
      else if (r < 40)
        send_word(CMD_INSERT, pick_key(), $urandom(), 4'($urandom()), 4'($urandom()));
      else if (r < 60)
        send_word(CMD_LOOKUP, pick_key(), $urandom(), 4'($urandom()), 4'($urandom()));
      else if (r < 78)
        send_word(CMD_DELETE, pick_key(), $urandom(), 4'($urandom()), 4'($urandom()));
      else if (r < 97)
        send_word(CMD_INSPECT, $urandom(), $urandom(), b, 4'($urandom_range(0, 15)));
      else
        send_word(3'($urandom_range(5, 7)), $urandom(), $urandom(), 4'($urandom()),
                  4'($urandom()));
    end
  endtask

  initial begin
    int guard;
    rst = 1'b1;
    start = 1'b0;
    in_word = '0;
    n_mismatch = 0;
    n_words = 0;
    n_results = 0;
    n_full = 0;
    n_removed = 0;
    cycles = 0;
    for (int i = 0; i < NBKT; i++) tbl_cnt[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(680);

    guard = 0;
    while (result_q.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    $display("%0d command words, %0d results, %0d refused as full, %0d deletes hit",
             n_words, n_results, n_full, n_removed);
    if (n_mismatch == 0 && result_q.size() == 0) begin
      $display("[chained_hash_table_engine_top] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, result_q.size());
      $display("[chained_hash_table_engine_top] ERROR");
    end
    $finish;
  end

endmodule
